// ===== rtl/irbs_pkg.sv =====
package irbs_pkg;

  // Frame and result widths.
  localparam int NUM_SENSORS = 7;
  localparam int SAMPLE_W    = 10;
  localparam int DUTY_W      = 16;
  localparam int FACTOR_W    = 16;
  localparam int DIFF_DEPTH  = 1 << SAMPLE_W;

  // Sensor positions, as reported on the strongest output.
  typedef enum logic [2:0] {
    SNS_EDGE_0   = 3'd0,
    SNS_TURN_1   = 3'd1,
    SNS_HARD_2   = 3'd2,
    SNS_CENTER_3 = 3'd3,
    SNS_HARD_4   = 3'd4,
    SNS_TURN_5   = 3'd5,
    SNS_EDGE_6   = 3'd6
  } sns_t;

  // Register map, decoded from paddr[2].
  typedef enum logic [0:0] {
    REG_LEFT_TOP  = 1'b0,
    REG_RIGHT_TOP = 1'b1
  } reg_idx_t;

  // exp(-1/70) in Q0.32, rounded to nearest.
  localparam logic [63:0] EXP_STEP_Q32 = 64'd4234046803;

  // floor(x * 15 / 100) for 16-bit x equals (x * PCT_MULT) >> PCT_SHIFT.
  localparam logic [24:0] PCT_MULT  = 25'd20132670;
  localparam int          PCT_SHIFT = 27;

  typedef logic [FACTOR_W-1:0] exp_table_t [DIFF_DEPTH];

  // Builds the Q0.16 factor table by the same rounded Q0.32 recurrence
  // that defines it, so every entry is exact.
  function automatic exp_table_t build_exp_table();
    exp_table_t  tbl;
    logic [63:0] acc;
    logic [63:0] rounded;
    acc = 64'd1 << 32;
    for (int d = 0; d < DIFF_DEPTH; d++) begin
      rounded = (acc + 64'd32768) >> 16;
      tbl[d]  = (rounded > 64'd65535) ? 16'hFFFF : rounded[FACTOR_W-1:0];
      acc     = (acc * EXP_STEP_Q32 + 64'd2147483648) >> 32;
    end
    return tbl;
  endfunction

  localparam exp_table_t EXP_TABLE = build_exp_table();

endpackage

// ===== rtl/ir_beacon_steering.sv =====
// Steering from one frame of seven 10-bit infrared levels. A frame request is
// taken on frame_valid/frame_ready and its result passes through the five
// stages (input register, argmax, exp table lookup, multiply, select) to the
// result channel; a new frame can be taken every cycle unless stalled, and up to five
// frames are held in flight. A stage stalls only when it and every stage after it hold a
// frame and the result is not taken. The strongest sensor (first maximum, all-zero gives 0) chooses the
// wheel compare values: edge sensors scale the inner wheel by exp(-|s0-s6|/70)
// from a 1024-entry Q0.16 table, sensors 1 and 5 by 15 percent, sensors 2 and 4
// stop it, and sensor 3 spins in place. Products are truncated. The timer tops
// sit at byte addresses 0 (left) and 4 (right), reset to 65535, and should only
// be written while no frame is in flight.
module ir_beacon_steering (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          frame_valid,
  output logic                          frame_ready,
  input  logic [irbs_pkg::SAMPLE_W-1:0] sensor_0,
  input  logic [irbs_pkg::SAMPLE_W-1:0] sensor_1,
  input  logic [irbs_pkg::SAMPLE_W-1:0] sensor_2,
  input  logic [irbs_pkg::SAMPLE_W-1:0] sensor_3,
  input  logic [irbs_pkg::SAMPLE_W-1:0] sensor_4,
  input  logic [irbs_pkg::SAMPLE_W-1:0] sensor_5,
  input  logic [irbs_pkg::SAMPLE_W-1:0] sensor_6,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [irbs_pkg::DUTY_W-1:0]   left_duty,
  output logic [irbs_pkg::DUTY_W-1:0]   right_duty,
  output logic                          dir_pin_a,
  output logic                          dir_pin_b,
  output logic [2:0]                    strongest,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import irbs_pkg::*;

  // Configuration registers.
  logic [DUTY_W-1:0] left_timer_top;
  logic [DUTY_W-1:0] right_timer_top;
  reg_idx_t          reg_idx;

  // Stage enables, from the result register back to the input register.
  logic en1, en2, en3, en4, en5;

  // Stage 1: input register.
  logic                st1_valid;
  logic [SAMPLE_W-1:0] st1_sensor [NUM_SENSORS];

  // Stage 1 combinational results.
  sns_t                best;
  logic [SAMPLE_W-1:0] max_level;
  logic [SAMPLE_W-1:0] diff;
  logic                dir_a;
  logic                dir_b;

  // Stage 2: argmax result.
  logic                st2_valid;
  sns_t                st2_best;
  logic [SAMPLE_W-1:0] st2_diff;
  logic                st2_dir_a, st2_dir_b;
  logic [DUTY_W-1:0]   st2_left_top, st2_right_top;

  // Stage 3: exp factor.
  logic                st3_valid;
  sns_t                st3_best;
  logic [FACTOR_W-1:0] st3_factor;
  logic                st3_dir_a, st3_dir_b;
  logic [DUTY_W-1:0]   st3_left_top, st3_right_top;

  // Stage 4: products.
  logic              st4_valid;
  sns_t              st4_best;
  logic [DUTY_W-1:0] st4_edge_duty;
  logic [DUTY_W-1:0] st4_turn_duty;
  logic              st4_dir_a, st4_dir_b;
  logic [DUTY_W-1:0] st4_left_top, st4_right_top;

  // Multiplier operands and products.
  logic [DUTY_W-1:0]           edge_top;
  logic [DUTY_W-1:0]           turn_top;
  logic [2*DUTY_W-1:0]         edge_prod;
  logic [DUTY_W+PCT_SHIFT-2:0] turn_prod;

  // Stage 5 next values.
  logic [DUTY_W-1:0] left_next, right_next;

  // APB register access; pready is tied high, so no access waits.
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      left_timer_top  <= 16'hFFFF;
      right_timer_top <= 16'hFFFF;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_LEFT_TOP:  left_timer_top  <= pwdata[DUTY_W-1:0];
        REG_RIGHT_TOP: right_timer_top <= pwdata[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LEFT_TOP:  prdata = {{(32-DUTY_W){1'b0}}, left_timer_top};
      REG_RIGHT_TOP: prdata = {{(32-DUTY_W){1'b0}}, right_timer_top};
      default:       prdata = '0;
    endcase
  end

  // Pipeline advance: a stage moves when it is empty or the next one moves.
  assign en5         = !result_valid || result_ready;
  assign en4         = !st4_valid || en5;
  assign en3         = !st3_valid || en4;
  assign en2         = !st2_valid || en3;
  assign en1         = !st1_valid || en2;
  assign frame_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      st1_valid    <= 1'b0;
      st2_valid    <= 1'b0;
      st3_valid    <= 1'b0;
      st4_valid    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (en1) st1_valid    <= frame_valid;
      if (en2) st2_valid    <= st1_valid;
      if (en3) st3_valid    <= st2_valid;
      if (en4) st4_valid    <= st3_valid;
      if (en5) result_valid <= st4_valid;
    end
  end

  // Stage 1: capture the frame.
  always_ff @(posedge clk) begin
    if (en1) begin
      st1_sensor[0] <= sensor_0;
      st1_sensor[1] <= sensor_1;
      st1_sensor[2] <= sensor_2;
      st1_sensor[3] <= sensor_3;
      st1_sensor[4] <= sensor_4;
      st1_sensor[5] <= sensor_5;
      st1_sensor[6] <= sensor_6;
    end
  end

  // First maximum over the frame, edge difference and spin direction.
  always_comb begin
    best      = SNS_EDGE_0;
    max_level = '0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      if (st1_sensor[i] > max_level) begin
        max_level = st1_sensor[i];
        best      = sns_t'(3'(i));
      end
    end
    diff = (st1_sensor[0] >= st1_sensor[6]) ? st1_sensor[0] - st1_sensor[6]
                                            : st1_sensor[6] - st1_sensor[0];
    if (best == SNS_CENTER_3) begin
      dir_a = st1_sensor[2] > st1_sensor[4];
      dir_b = !dir_a;
    end else begin
      dir_a = 1'b1;
      dir_b = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      st2_best      <= best;
      st2_diff      <= diff;
      st2_dir_a     <= dir_a;
      st2_dir_b     <= dir_b;
      st2_left_top  <= left_timer_top;
      st2_right_top <= right_timer_top;
    end
  end

  // Stage 3: factor lookup.
  always_ff @(posedge clk) begin
    if (en3) begin
      st3_best      <= st2_best;
      st3_factor    <= EXP_TABLE[st2_diff];
      st3_dir_a     <= st2_dir_a;
      st3_dir_b     <= st2_dir_b;
      st3_left_top  <= st2_left_top;
      st3_right_top <= st2_right_top;
    end
  end

  // Stage 4: scale the inner wheel; only the product for the chosen case is used.
  assign edge_top  = (st3_best == SNS_EDGE_0) ? st3_right_top : st3_left_top;
  assign turn_top  = (st3_best == SNS_TURN_1) ? st3_right_top : st3_left_top;
  assign edge_prod = (2*DUTY_W)'(st3_factor) * (2*DUTY_W)'(edge_top);
  assign turn_prod = (DUTY_W+PCT_SHIFT-1)'(turn_top) * (DUTY_W+PCT_SHIFT-1)'(PCT_MULT);

  always_ff @(posedge clk) begin
    if (en4) begin
      st4_best      <= st3_best;
      st4_edge_duty <= edge_prod[2*DUTY_W-1:DUTY_W];
      st4_turn_duty <= DUTY_W'(turn_prod[DUTY_W+PCT_SHIFT-2:PCT_SHIFT]);
      st4_dir_a     <= st3_dir_a;
      st4_dir_b     <= st3_dir_b;
      st4_left_top  <= st3_left_top;
      st4_right_top <= st3_right_top;
    end
  end

  // Stage 5: pick the wheel values for the strongest sensor.
  always_comb begin
    left_next  = st4_left_top;
    right_next = st4_right_top;
    unique case (st4_best)
      SNS_EDGE_0:   right_next = st4_edge_duty;
      SNS_TURN_1:   right_next = st4_turn_duty;
      SNS_HARD_2:   right_next = '0;
      SNS_CENTER_3: ;
      SNS_HARD_4:   left_next  = '0;
      SNS_TURN_5:   left_next  = st4_turn_duty;
      SNS_EDGE_6:   left_next  = st4_edge_duty;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      left_duty  <= left_next;
      right_duty <= right_next;
      dir_pin_a  <= st4_dir_a;
      dir_pin_b  <= st4_dir_b;
      strongest  <= st4_best;
    end
  end

  // A reversed wheel only comes from the center sensor, and never both wheels.
  a_spin_only_center: assert property (@(posedge clk) disable iff (rst)
    result_valid && (!dir_pin_a || !dir_pin_b) |->
      (strongest == SNS_CENTER_3) && (dir_pin_a ^ dir_pin_b))
    else $error("reversed wheel outside a center spin");

  // The hard-turn sensors stop the inner wheel.
  a_hard_turn_stops: assert property (@(posedge clk) disable iff (rst)
    result_valid && (strongest == SNS_HARD_2 || strongest == SNS_HARD_4) |->
      ((strongest == SNS_HARD_2) ? right_duty == '0 : left_duty == '0))
    else $error("hard turn without a stopped wheel");

  // With the result register empty, no stage may hold back a new frame.
  a_empty_takes_frame: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> frame_ready)
    else $error("frame refused while the result register is empty");

  // A taken frame enters the first stage.
  a_frame_enters: assert property (@(posedge clk) disable iff (rst)
    frame_valid && frame_ready |=> st1_valid)
    else $error("accepted frame lost at the input register");

endmodule
